### src/mfab_pkg.sv
// ----------------------------------------------------------------------------
// mfab_pkg: shared types and constants for the multi-format alpha blender
// Mode codes, lane masks and the configuration bundle seen by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mfab_pkg;

  localparam int PixelWidth = 32;

  // Blend modes
  localparam logic [2:0] MODE_RGB888_SURF = 3'd0;
  localparam logic [2:0] MODE_ARGB_PIXEL  = 3'd1;
  localparam logic [2:0] MODE_565_SURF    = 3'd2;
  localparam logic [2:0] MODE_555_SURF    = 3'd3;
  localparam logic [2:0] MODE_ARGB_TO_565 = 3'd4;
  localparam logic [2:0] MODE_ARGB_TO_555 = 3'd5;

  // Configuration register indexes
  localparam logic REG_BLEND_MODE    = 1'b0;
  localparam logic REG_SURFACE_ALPHA = 1'b1;

  localparam logic [2:0] BLEND_MODE_RESET    = MODE_RGB888_SURF;
  localparam logic [7:0] SURFACE_ALPHA_RESET = 8'hff;

  localparam logic [31:0] MASK_RB       = 32'h00ff00ff;
  localparam logic [31:0] MASK_G        = 32'h0000ff00;
  localparam logic [31:0] MASK_HALF888  = 32'h00fefefe;
  localparam logic [31:0] MASK_LSB888   = 32'h00010101;
  localparam logic [31:0] ALPHA_OPAQUE  = 32'hff000000;
  localparam logic [31:0] LANES565      = 32'h07e0f81f;
  localparam logic [31:0] LANES555      = 32'h03e07c1f;
  localparam logic [15:0] MASK_HALF565  = 16'hf7de;
  localparam logic [15:0] MASK_HALF555  = 16'hfbde;

  typedef struct packed {
    logic [2:0] blend_mode;
    logic [7:0] surface_alpha;
  } cfg_t;

endpackage

`default_nettype wire

### src/mfab_blend_core.sv
// ----------------------------------------------------------------------------
// mfab_blend_core: combinational pixel blend
// Blends one source and one destination pixel in the selected mode. One
// shared multiplier serves the red/blue word and the 16-bit packed lanes,
// a second one serves the green channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mfab_blend_core (
  input  wire mfab_pkg::cfg_t cfg,
  input  wire logic [31:0]    src_pixel,
  input  wire logic [31:0]    dst_pixel,
  output logic [31:0]         out_pixel
);

  logic [2:0]  mode;
  logic [7:0]  alpha;
  logic        is_lanes;
  logic        is_565;
  logic [7:0]  a8;
  logic [4:0]  a5;
  logic [31:0] rb_dst;
  logic [31:0] rb_diff;
  logic [31:0] g_dst;
  logic [31:0] g_diff;
  logic [31:0] g_prod;
  logic [31:0] g_res;
  logic [31:0] rb_res;
  logic [31:0] lane_mask;
  logic [31:0] src_lane;
  logic [31:0] dst_lane;
  logic [31:0] lane_diff;
  logic [31:0] lane_sum;
  logic [31:0] lane_res;
  logic [31:0] mul_a;
  logic [7:0]  mul_k;
  logic [31:0] prod;
  logic [31:0] blend;
  logic [31:0] half888;
  logic [16:0] half_sum;
  logic [15:0] half_mask;
  logic [31:0] half16;
  logic [31:0] copy565;
  logic [31:0] copy555;

  assign mode  = cfg.blend_mode;
  assign alpha = cfg.surface_alpha;

  assign is_lanes = (mode == mfab_pkg::MODE_565_SURF) || (mode == mfab_pkg::MODE_555_SURF)
                 || (mode == mfab_pkg::MODE_ARGB_TO_565)
                 || (mode == mfab_pkg::MODE_ARGB_TO_555);
  assign is_565   = (mode == mfab_pkg::MODE_565_SURF) || (mode == mfab_pkg::MODE_ARGB_TO_565);

  assign a8 = (mode == mfab_pkg::MODE_ARGB_PIXEL) ? src_pixel[31:24] : alpha;
  assign a5 = ((mode == mfab_pkg::MODE_565_SURF) || (mode == mfab_pkg::MODE_555_SURF))
            ? alpha[7:3] : src_pixel[31:27];

  // 8-bit channels: red and blue share one word, green on its own
  assign rb_dst  = dst_pixel & mfab_pkg::MASK_RB;
  assign rb_diff = (src_pixel & mfab_pkg::MASK_RB) - rb_dst;
  assign g_dst   = dst_pixel & mfab_pkg::MASK_G;
  assign g_diff  = (src_pixel & mfab_pkg::MASK_G) - g_dst;
  assign g_prod  = g_diff * {24'd0, a8};
  assign g_res   = (g_dst + (g_prod >> 8)) & mfab_pkg::MASK_G;

  // 16-bit formats: move green to the high half so all lanes blend at once
  assign lane_mask = is_565 ? mfab_pkg::LANES565 : mfab_pkg::LANES555;
  assign dst_lane  = {dst_pixel[15:0], dst_pixel[15:0]} & lane_mask;

  always_comb begin
    unique case (mode)
      mfab_pkg::MODE_ARGB_TO_565: begin
        src_lane = ({16'd0, src_pixel[15:10], 10'd0} << 11)
                 + ({8'd0, src_pixel[31:8]} & 32'h0000f800)
                 + {27'd0, src_pixel[7:3]};
      end
      mfab_pkg::MODE_ARGB_TO_555: begin
        src_lane = ({16'd0, src_pixel[15:11], 11'd0} << 10)
                 + ({9'd0, src_pixel[31:9]} & 32'h00007c00)
                 + {27'd0, src_pixel[7:3]};
      end
      default: begin
        src_lane = {src_pixel[15:0], src_pixel[15:0]} & lane_mask;
      end
    endcase
  end

  assign lane_diff = src_lane - dst_lane;

  // Shared multiplier: red/blue word or packed lanes
  assign mul_a = is_lanes ? lane_diff : rb_diff;
  assign mul_k = is_lanes ? {3'd0, a5} : a8;
  assign prod  = mul_a * {24'd0, mul_k};

  assign rb_res   = (rb_dst + (prod >> 8)) & mfab_pkg::MASK_RB;
  assign lane_sum = (dst_lane + (prod >> 5)) & lane_mask;
  assign lane_res = {16'd0, lane_sum[15:0] | lane_sum[31:16]};
  assign blend    = rb_res | g_res;

  // 50% shortcuts
  assign half888 = (((src_pixel & mfab_pkg::MASK_HALF888)
                   + (dst_pixel & mfab_pkg::MASK_HALF888)) >> 1)
                 + (src_pixel & dst_pixel & mfab_pkg::MASK_LSB888);
  assign half_mask = is_565 ? mfab_pkg::MASK_HALF565 : mfab_pkg::MASK_HALF555;
  assign half_sum  = {1'b0, src_pixel[15:0] & half_mask}
                   + {1'b0, dst_pixel[15:0] & half_mask};
  assign half16    = {16'd0, half_sum[16:1]
                   + (src_pixel[15:0] & dst_pixel[15:0] & ~half_mask)};

  // Opaque source copied straight into the 16-bit format
  assign copy565 = {16'd0, src_pixel[23:19], src_pixel[15:10], src_pixel[7:3]};
  assign copy555 = {17'd0, src_pixel[23:19], src_pixel[15:11], src_pixel[7:3]};

  always_comb begin
    unique case (mode)
      mfab_pkg::MODE_RGB888_SURF: begin
        out_pixel = ((alpha == 8'd128) ? half888 : blend) | mfab_pkg::ALPHA_OPAQUE;
      end
      mfab_pkg::MODE_ARGB_PIXEL: begin
        out_pixel = (src_pixel[31:24] == 8'hff) ? src_pixel
                  : (blend | (dst_pixel & mfab_pkg::ALPHA_OPAQUE));
      end
      mfab_pkg::MODE_565_SURF, mfab_pkg::MODE_555_SURF: begin
        out_pixel = (alpha == 8'd128) ? half16 : lane_res;
      end
      mfab_pkg::MODE_ARGB_TO_565: begin
        out_pixel = (src_pixel[31:27] == 5'h1f) ? copy565 : lane_res;
      end
      mfab_pkg::MODE_ARGB_TO_555: begin
        out_pixel = (src_pixel[31:27] == 5'h1f) ? copy555 : lane_res;
      end
      default: begin
        out_pixel = dst_pixel;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/multi_format_alpha_blender.sv
// ----------------------------------------------------------------------------
// multi_format_alpha_blender: per-pixel alpha blend in six formats
// Streaming pixel blender with surface or pixel alpha.
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on the s_axis side carries a source pixel (tdata[31:0])
//   and a destination pixel (tdata[63:32]); the m_axis side returns one
//   blended pixel per input transaction, in order.
//   Blend mode and surface alpha are written through wr_en/wr_index/wr_data
//   while no transaction is in flight.
//   There is one input register, then the blend logic into the result
//   register. Throughput is one pixel per cycle while the receiver keeps
//   m_axis_tready high, set by the single pass through the blend datapath.
//   When the receiver holds m_axis_tready low, the result register holds its
//   pixel and the input register, if empty, takes one more transaction before
//   s_axis_tready drops.
//   Reset clears both valid flags and loads mode 0 with surface alpha 255.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_format_alpha_blender (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // src_pixel[31:0], dst_pixel[63:32]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // out_pixel[31:0]
  input  wire logic        wr_en,
  input  wire logic        wr_index,
  input  wire logic [7:0]  wr_data
);

  mfab_pkg::cfg_t cfg;
  logic           in_valid;
  logic [31:0]    src_q;
  logic [31:0]    dst_q;
  logic           out_valid;
  logic [31:0]    out_pixel;
  logic [31:0]    blend_next;
  logic           out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blend_mode    <= mfab_pkg::BLEND_MODE_RESET;
      cfg.surface_alpha <= mfab_pkg::SURFACE_ALPHA_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        mfab_pkg::REG_BLEND_MODE:    cfg.blend_mode    <= wr_data[2:0];
        mfab_pkg::REG_SURFACE_ALPHA: cfg.surface_alpha <= wr_data;
        default: ;
      endcase
    end
  end

  // Advance the input stage whenever the result register frees up
  assign out_load      = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      src_q <= s_axis_tdata[31:0];
      dst_q <= s_axis_tdata[63:32];
    end
  end

  mfab_blend_core u_core (
    .cfg       (cfg),
    .src_pixel (src_q),
    .dst_pixel (dst_q),
    .out_pixel (blend_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel <= blend_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_pixel;

endmodule

`default_nettype wire

### bench/multi_format_alpha_blender_test.sv
// ----------------------------------------------------------------------------
// multi_format_alpha_blender_test: self-checking bench for the pixel blender
// Streams source/destination pixel pairs through every blend mode and several
// surface alpha settings. A scoreboard predicts each blended pixel and compares
// it with what leaves the master side. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module multi_format_alpha_blender_test;

  // Mode codes the block treats as pass-through
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [7:0] HALF_ALPHA    = 8'd128;

  class pixel_scoreboard;
    logic [2:0]  mode;
    logic [7:0]  alpha;
    logic [31:0] pending[$];
    int          failures;

    function new();
      mode     = mfab_pkg::BLEND_MODE_RESET;
      alpha    = mfab_pkg::SURFACE_ALPHA_RESET;
      failures = 0;
    endfunction

    function void set_config(logic [7:0] mode_word, logic [7:0] alpha_val);
      mode  = mode_word[2:0];
      alpha = alpha_val;
    endfunction

    // Red/blue pair and green blended separately in one 32-bit word
    function logic [31:0] mix_rgb(logic [31:0] s, logic [31:0] d, logic [31:0] a);
      logic [31:0] rb;
      logic [31:0] g;
      logic [31:0] t;
      rb = d & mfab_pkg::MASK_RB;
      t  = ((s & mfab_pkg::MASK_RB) - rb) * a;
      rb = (rb + (t >> 8)) & mfab_pkg::MASK_RB;
      g  = d & mfab_pkg::MASK_G;
      t  = ((s & mfab_pkg::MASK_G) - g) * a;
      g  = (g + (t >> 8)) & mfab_pkg::MASK_G;
      return rb | g;
    endfunction

    // Source already in lane layout; destination spread across both halves
    function logic [31:0] lane_mix(logic [31:0] s, logic [31:0] d, logic [31:0] a5,
                                   logic [31:0] lanes);
      logic [31:0] w;
      logic [31:0] t;
      w = {d[15:0], d[15:0]} & lanes;
      t = (s - w) * a5;
      w = (w + (t >> 5)) & lanes;
      return {16'h0000, w[15:0] | w[31:16]};
    endfunction

    function logic [31:0] halve16(logic [31:0] s, logic [31:0] d, logic [15:0] mask);
      logic [16:0] sum;
      sum = {1'b0, s[15:0] & mask} + {1'b0, d[15:0] & mask};
      return {16'h0000, sum[16:1] + (s[15:0] & d[15:0] & ~mask)};
    endfunction

    function logic [31:0] blend_pixel(logic [31:0] s, logic [31:0] d);
      logic [31:0] r;
      logic [31:0] wide;
      logic [31:0] lanes;
      logic [15:0] mask50;
      case (mode)
        mfab_pkg::MODE_RGB888_SURF: begin
          if (alpha == HALF_ALPHA)
            r = ((((s & mfab_pkg::MASK_HALF888) + (d & mfab_pkg::MASK_HALF888)) >> 1)
                 + (s & d & mfab_pkg::MASK_LSB888)) | mfab_pkg::ALPHA_OPAQUE;
          else
            r = mix_rgb(s, d, {24'h0, alpha}) | mfab_pkg::ALPHA_OPAQUE;
        end
        mfab_pkg::MODE_ARGB_PIXEL: begin
          if (s[31:24] == 8'hff)
            r = s;
          else
            r = mix_rgb(s, d, {24'h0, s[31:24]}) | (d & mfab_pkg::ALPHA_OPAQUE);
        end
        mfab_pkg::MODE_565_SURF, mfab_pkg::MODE_555_SURF: begin
          mask50 = (mode == mfab_pkg::MODE_565_SURF) ? mfab_pkg::MASK_HALF565
                                                     : mfab_pkg::MASK_HALF555;
          lanes  = (mode == mfab_pkg::MODE_565_SURF) ? mfab_pkg::LANES565
                                                     : mfab_pkg::LANES555;
          if (alpha == HALF_ALPHA) begin
            r = halve16(s, d, mask50);
          end else begin
            wide = {s[15:0], s[15:0]} & lanes;
            r    = lane_mix(wide, d, {27'h0, alpha[7:3]}, lanes);
          end
        end
        mfab_pkg::MODE_ARGB_TO_565: begin
          if (s[31:27] == 5'h1f) begin
            r = {16'h0000, s[23:19], s[15:10], s[7:3]};
          end else begin
            wide = {5'h00, s[15:10], 5'h00, s[23:19], 6'h00, s[7:3]};
            r    = lane_mix(wide, d, {27'h0, s[31:27]}, mfab_pkg::LANES565);
          end
        end
        mfab_pkg::MODE_ARGB_TO_555: begin
          if (s[31:27] == 5'h1f) begin
            r = {17'h00000, s[23:19], s[15:11], s[7:3]};
          end else begin
            wide = {6'h00, s[15:11], 6'h00, s[23:19], 5'h00, s[7:3]};
            r    = lane_mix(wide, d, {27'h0, s[31:27]}, mfab_pkg::LANES555);
          end
        end
        default: r = d;
      endcase
      return r;
    endfunction

    function void note_input(logic [31:0] src, logic [31:0] dst);
      pending.push_back(blend_pixel(src, dst));
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending.size() == 0) begin
        $error("out_pixel: expected nothing, got %h", got);
        failures++;
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          $error("out_pixel: expected %h, got %h", want, got);
          failures++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = 64'h0;   // src_pixel[31:0], dst_pixel[63:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // out_pixel[31:0]
  logic        wr_en = 1'b0;
  logic        wr_index = mfab_pkg::REG_BLEND_MODE;
  logic [7:0]  wr_data = 8'h00;
  logic        steady = 1'b0;

  pixel_scoreboard sb;

  multi_format_alpha_blender dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data)
  );

  always #1 clk = ~clk;

  // Receiver: stall about a quarter of the time unless in the steady stretch
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      sb.note_input(s_axis_tdata[31:0], s_axis_tdata[63:32]);
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata);
  end

  task automatic send_pixel(logic [31:0] src, logic [31:0] dst);
    while (!steady && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dst, src};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Hold the sender until every transaction has come back out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    // Let the monitor log the last accepted transaction before counting
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_blender(logic [7:0] mode_word, logic [7:0] alpha_val);
    wait_idle();
    wr_en    <= 1'b1;
    wr_index <= mfab_pkg::REG_BLEND_MODE;
    wr_data  <= mode_word;
    @(posedge clk);
    wr_index <= mfab_pkg::REG_SURFACE_ALPHA;
    wr_data  <= alpha_val;
    @(posedge clk);
    wr_en <= 1'b0;
    sb.set_config(mode_word, alpha_val);
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  mode_word;
    logic [7:0]  alpha_val;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings first, then the corners of each mode
    send_pixel(32'h12345678, 32'h9abcdef0);
    program_blender(mfab_pkg::MODE_RGB888_SURF, HALF_ALPHA);
    send_pixel(32'hffffffff, 32'h00000000);
    send_pixel(32'h00010101, 32'h00010101);
    program_blender(mfab_pkg::MODE_RGB888_SURF, 8'd0);
    send_pixel(32'hffffffff, 32'h00000000);
    program_blender(mfab_pkg::MODE_RGB888_SURF, 8'd255);
    send_pixel(32'h00000000, 32'hffffffff);
    program_blender(mfab_pkg::MODE_ARGB_PIXEL, 8'h5a);
    send_pixel(32'hff123456, 32'h00abcdef);
    send_pixel(32'h00ffffff, 32'hff000000);
    send_pixel(32'h80ff00ff, 32'h7f00ff00);
    program_blender(mfab_pkg::MODE_565_SURF, HALF_ALPHA);
    send_pixel(32'h0000ffff, 32'h0000ffff);
    program_blender(mfab_pkg::MODE_565_SURF, 8'd0);
    send_pixel(32'hffffffff, 32'h00000000);
    program_blender(mfab_pkg::MODE_565_SURF, 8'd255);
    send_pixel(32'h0000f81f, 32'hffff07e0);
    program_blender(mfab_pkg::MODE_555_SURF, HALF_ALPHA);
    send_pixel(32'h0000ffff, 32'h0000ffff);
    program_blender(mfab_pkg::MODE_555_SURF, 8'd7);
    send_pixel(32'hffff7fff, 32'h00000000);
    program_blender(mfab_pkg::MODE_555_SURF, 8'd255);
    send_pixel(32'h00007c1f, 32'hffff83e0);
    program_blender(mfab_pkg::MODE_ARGB_TO_565, 8'd255);
    send_pixel(32'hffffffff, 32'h00000000);
    send_pixel(32'h07ffffff, 32'hffffffff);
    send_pixel(32'h80a0b0c0, 32'h12345678);
    program_blender(mfab_pkg::MODE_ARGB_TO_555, 8'd0);
    send_pixel(32'hf8ffffff, 32'hffffffff);
    send_pixel(32'h07ffffff, 32'hffffffff);
    send_pixel(32'h80a0b0c0, 32'h12345678);
    program_blender(MODE_SPARE_LO, 8'd64);
    send_pixel(32'hdeadbeef, 32'hcafef00d);
    // Upper bits of the mode word are ignored by the block
    program_blender({5'b11111, MODE_SPARE_HI}, 8'd200);
    send_pixel(32'h01234567, 32'h89abcdef);

    // Random phases: each mode twice, alpha leaning on its corners
    for (int phase = 0; phase < 16; phase++) begin
      mode_word = {3'($urandom_range(0, 7)) & {3{phase[3]}}, 2'b00, 3'(phase % 8)};
      case ($urandom_range(0, 5))
        0: alpha_val = 8'd0;
        1: alpha_val = 8'd255;
        2: alpha_val = HALF_ALPHA;
        default: alpha_val = 8'($urandom);
      endcase
      program_blender(mode_word, alpha_val);
      steady <= (phase == 5);
      for (int n = 0; n < 125; n++) begin
        src = $urandom;
        dst = $urandom;
        case ($urandom_range(0, 7))
          0: src[31:24] = 8'hff;
          1: src[31:27] = 5'h1f;
          2: src[31:24] = 8'h00;
          default: ;
        endcase
        send_pixel(src, dst);
      end
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      steady <= 1'b0;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
